>>> rtl/lps_pkg.sv
package lps_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned KIND_COUNT = 6;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CONFIGURE = 2'd0,
    OP_REQUEST   = 2'd1,
    OP_COMPLETE  = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFG_WRITE,
    ST_SCAN_READ,
    ST_SCAN_CHECK,
    ST_CMP_READ,
    ST_CMP_WRITE,
    ST_OUT
  } state_t;

  localparam logic [1:0] PRIO_CRITICAL = 2'd0;
  localparam logic [1:0] PRIO_HIGH     = 2'd1;
  localparam logic [1:0] PRIO_NORMAL   = 2'd2;
  localparam logic [1:0] PRIO_LOW      = 2'd3;

  localparam logic [2:0] KIND_STATUS      = 3'd0;
  localparam logic [2:0] KIND_PRESENCE    = 3'd1;
  localparam logic [2:0] KIND_ELECTRICAL  = 3'd2;
  localparam logic [2:0] KIND_TEMPERATURE = 3'd3;
  localparam logic [2:0] KIND_LIFETIME    = 3'd4;
  localparam logic [2:0] KIND_IDENTITY    = 3'd5;

  localparam logic [0:0] CFG_NORMAL_LIMIT     = 1'b0;
  localparam logic [0:0] CFG_DIAGNOSTIC_LIMIT = 1'b1;

  // Saturating add of a time and an interval of at most 27 bits.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [26:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W-26){1'b0}}, d};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // Seed interval for a kind at configure time.
  function automatic logic [26:0] seed_of(input logic [2:0] k);
    logic [26:0] r;
    case (k)
      KIND_STATUS:   r = 27'd0;
      KIND_PRESENCE: r = 27'd30000;
      KIND_LIFETIME: r = 27'd21600000;
      KIND_IDENTITY: r = 27'd86400000;
      default:       r = 27'd60000;
    endcase
    return r;
  endfunction

  // Flags: bit 0 warning, bit 1 fault, bit 2 commanded on.
  function automatic logic [1:0] prio_of(input logic [2:0] k, input logic [2:0] f);
    logic [1:0] r;
    case (k)
      KIND_STATUS:   r = (f[1:0] != 2'b00) ? PRIO_CRITICAL : PRIO_HIGH;
      KIND_PRESENCE: r = PRIO_HIGH;
      KIND_LIFETIME, KIND_IDENTITY: r = PRIO_LOW;
      default:       r = PRIO_NORMAL;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/light_poll_scheduler_top.sv
// Steps: configure writes one due-time entry per kind (none for a bad address),
// complete reads then writes one entry, other ops go straight to output, request
// examines light/kind entries in turn from the cursor. One request is in flight at a time;
// the due-time memory's registered read gives each entry examined a read and a check state.
// Reset (synchronous, rst_n low) clears the configured bits, the cursor, the
// state machine and the output valid and loads the limit resets; memories are not cleared.
module light_poll_scheduler_top #(
  parameter int unsigned MAX_LIGHTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // op[1:0], light_address[9:2], poll_kind[12:10], warning_active[13],
  // recent_fault[14], commanded_on[15], observation_start_ms[63:16],
  // now_ms[111:64], utilisation[127:112]
  input  logic [127:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // granted[0], grant_address[8:1], grant_kind[11:9], grant_priority[13:12]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  import lps_pkg::*;

  localparam int unsigned AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned DEPTH = MAX_LIGHTS * KIND_COUNT;
  localparam int unsigned DW = $clog2(DEPTH);

  // Decoded request fields.
  logic [1:0]        f_op;
  logic [7:0]        f_addr;
  logic [2:0]        f_kind;
  logic [2:0]        f_flags;
  logic [TIME_W-1:0] f_start;
  logic [TIME_W-1:0] f_now;
  logic [15:0]       f_util;
  assign f_op    = in_tdata[1:0];
  assign f_addr  = in_tdata[9:2];
  assign f_kind  = in_tdata[12:10];
  assign f_flags = in_tdata[15:13];
  assign f_start = in_tdata[63:16];
  assign f_now   = in_tdata[111:64];
  assign f_util  = in_tdata[127:112];

  state_t state_r, state_nxt;

  logic [1:0]        op_r;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [2:0]        cflags_r;
  logic [TIME_W-1:0] cstart_r, now_r;
  logic [15:0]       util_r;
  logic              addr_ok_r;
  logic [AW:0]       scanned_r, scanned_nxt;
  logic [AW-1:0]     cursor_r, cursor_nxt;
  logic [14:0]       normal_limit_r, diag_limit_r;
  logic [MAX_LIGHTS-1:0] configured_r;
  logic [15:0]       out_data_r, out_data_nxt;
  logic              out_valid_r;

  // Memories: due times per light and kind, per-light flags and start.
  logic [TIME_W-1:0] due_mem [DEPTH];
  logic [2:0]        flag_mem [MAX_LIGHTS];
  logic [TIME_W-1:0] start_mem [MAX_LIGHTS];
  logic [TIME_W-1:0] due_q, start_q;
  logic [2:0]        flag_q;

  logic              due_we;
  logic [DW-1:0]     due_waddr, due_raddr;
  logic [TIME_W-1:0] due_wdata;
  logic              ctx_we;

  logic [DW-1:0] entry_idx;
  logic [DW+3:0] entry_wide;
  assign entry_wide = {{4{1'b0}}, {(DW-AW){1'b0}}, addr_r} * (DW + 4)'(KIND_COUNT)
                      + (DW + 4)'(kind_r);
  assign entry_idx = entry_wide[DW-1:0];

  always_ff @(posedge clk) begin
    if (due_we) begin
      due_mem[due_waddr] <= due_wdata;
    end
    due_q <= due_mem[due_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctx_we) begin
      flag_mem[addr_r]  <= cflags_r;
      start_mem[addr_r] <= cstart_r;
    end
    flag_q  <= flag_mem[addr_r];
    start_q <= start_mem[addr_r];
  end

  // Poll interval per kind, with the fast-then-slower fault backoff for status.
  logic [TIME_W-1:0] elapsed;
  logic [26:0]       interval;
  always_comb begin
    elapsed = (now_r >= start_q) ? (now_r - start_q) : '0;
    case (kind_r)
      KIND_STATUS: begin
        if (flag_q[1:0] != 2'b00 && elapsed < TIME_W'(60000)) begin
          interval = 27'd2000;
        end else if (flag_q[1:0] != 2'b00 && elapsed < TIME_W'(360000)) begin
          interval = 27'd5000;
        end else begin
          interval = flag_q[2] ? 27'd5000 : 27'd30000;
        end
      end
      KIND_PRESENCE:    interval = 27'd30000;
      KIND_ELECTRICAL:  interval = (flag_q[1:0] != 2'b00) ? 27'd10000 : 27'd60000;
      KIND_TEMPERATURE: interval = flag_q[0] ? 27'd10000 : 27'd60000;
      KIND_LIFETIME:    interval = 27'd21600000;
      default:          interval = 27'd86400000;
    endcase
  end

  // Admission of the entry read in ST_SCAN_READ.
  logic [1:0]  scan_prio;
  logic [14:0] scan_lim;
  logic        scan_hit;
  logic        last_kind;
  logic [AW:0] addr_inc;
  logic [AW-1:0] addr_wrap;
  always_comb begin
    scan_prio = prio_of(kind_r, flag_q);
    scan_lim  = (scan_prio == PRIO_CRITICAL) ? diag_limit_r : normal_limit_r;
    scan_hit  = configured_r[addr_r] && (due_q <= now_r) && !util_r[15]
                && (util_r[14:0] < scan_lim);
    last_kind = (kind_r == 3'(KIND_COUNT - 1)) || !configured_r[addr_r];
    addr_inc  = {1'b0, addr_r} + (AW + 1)'(1);
    addr_wrap = (addr_inc == (AW + 1)'(MAX_LIGHTS)) ? '0 : addr_inc[AW-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          case (op_t'(f_op))
            OP_CONFIGURE: state_nxt = ST_CFG_WRITE;
            OP_REQUEST:   state_nxt = ST_SCAN_READ;
            OP_COMPLETE:  state_nxt = ST_CMP_READ;
            default:      state_nxt = ST_OUT;
          endcase
        end
      end
      ST_CFG_WRITE: begin
        if (!addr_ok_r || kind_r == 3'(KIND_COUNT - 1)) state_nxt = ST_OUT;
      end
      ST_SCAN_READ: state_nxt = ST_SCAN_CHECK;
      ST_SCAN_CHECK: begin
        if (scan_hit) begin
          state_nxt = ST_OUT;
        end else if (last_kind && scanned_r == (AW + 1)'(MAX_LIGHTS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SCAN_READ;
        end
      end
      ST_CMP_READ: state_nxt = ST_CMP_WRITE;
      ST_CMP_WRITE: state_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    addr_nxt     = addr_r;
    kind_nxt     = kind_r;
    scanned_nxt  = scanned_r;
    cursor_nxt   = cursor_r;
    out_data_nxt = out_data_r;
    due_we       = 1'b0;
    due_waddr    = entry_idx;
    due_raddr    = entry_idx;
    due_wdata    = sat_add(now_r, seed_of(kind_r));
    ctx_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        out_data_nxt = '0;
        kind_nxt     = (op_t'(f_op) == OP_COMPLETE) ? f_kind : '0;
        addr_nxt     = (op_t'(f_op) == OP_REQUEST) ? cursor_r : f_addr[AW-1:0];
        scanned_nxt  = '0;
      end
      ST_CFG_WRITE: begin
        due_we = addr_ok_r;
        ctx_we = addr_ok_r && kind_r == '0;
        kind_nxt = kind_r + 3'd1;
        if (addr_ok_r && kind_r == 3'(KIND_COUNT - 1)) out_data_nxt = 16'd1;
      end
      ST_SCAN_CHECK: begin
        if (scan_hit) begin
          out_data_nxt = {scan_prio, kind_r, 8'(addr_r), 1'b1};
          cursor_nxt   = addr_wrap;
        end else if (last_kind) begin
          kind_nxt    = '0;
          addr_nxt    = addr_wrap;
          scanned_nxt = scanned_r + (AW + 1)'(1);
        end else begin
          kind_nxt = kind_r + 3'd1;
        end
      end
      ST_CMP_WRITE: begin
        if (addr_ok_r && kind_r < 3'(KIND_COUNT) && configured_r[addr_r]) begin
          due_we       = 1'b1;
          due_wdata    = sat_add(now_r, interval);
          out_data_nxt = 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    kind_r     <= kind_nxt;
    scanned_r  <= scanned_nxt;
    out_data_r <= out_data_nxt;
    if (state_r == ST_IDLE && in_tvalid && in_tready) begin
      op_r      <= f_op;
      cflags_r  <= f_flags;
      cstart_r  <= f_start;
      now_r     <= f_now;
      util_r    <= f_util;
      addr_ok_r <= (9'(f_addr) < 9'(MAX_LIGHTS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cursor_r       <= '0;
      configured_r   <= '0;
      out_valid_r    <= 1'b0;
      normal_limit_r <= 15'd3277;
      diag_limit_r   <= 15'd3891;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      if (state_r == ST_CFG_WRITE && addr_ok_r) configured_r[addr_r] <= 1'b1;
      if (state_r != ST_OUT && state_nxt == ST_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NORMAL_LIMIT:     normal_limit_r <= cfg_data;
          CFG_DIAGNOSTIC_LIMIT: diag_limit_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Outputs.
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
    cfg_ready  = 1'b1;
  end

  // A request grant always names a configured light.
  a_grant_configured: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0] && op_r == OP_REQUEST)
      |-> configured_r[out_data_r[AW:1]])
    else $error("grant to unconfigured light");
  // The cursor moves only on a request grant.
  a_cursor_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_nxt != cursor_r) |-> (state_r == ST_SCAN_CHECK && scan_hit))
    else $error("cursor moved without a grant");
  // No new request is taken while a result is pending.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready)
    else $error("request accepted while a result is pending");

endmodule
